// ----- rtl/pva_pkg.sv -----
// shared types and constants for the voice allocator
package pva_pkg;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] ACTIVE_MAX = 4'd15;

    typedef enum logic [1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_ALL_OFF  = 2'd2,
        REQ_TICK     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_TALLY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic apply;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } status_t;

endpackage

// ----- rtl/pva_ctrl.sv -----
// sequencer for the voice allocator: accept, search scan, update, tally scan, publish
module pva_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pva_pkg::status_t  status,
    output pva_pkg::cmd_t     cmd
);

    pva_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pva_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = pva_pkg::ST_SEARCH;
                end
            end
            pva_pkg::ST_SEARCH:
            begin
                if (status.scan_done)
                    state_next = pva_pkg::ST_APPLY;
            end
            pva_pkg::ST_APPLY:
            begin
                // slot update lands at this edge, tally scan reads the new state
                cmd.apply      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = pva_pkg::ST_TALLY;
            end
            pva_pkg::ST_TALLY:
            begin
                if (status.scan_done)
                    state_next = pva_pkg::ST_FINISH;
            end
            pva_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/pva_datapath.sv -----
// slot state, note/stamp memory, scan accumulators and result registers
module pva_datapath
#(
    parameter int VOICES = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pva_pkg::cmd_t                       cmd,
    output pva_pkg::status_t                    status,
    input  logic [1:0]                          req_type,
    input  logic [pva_pkg::NOTE_W-1:0]          note,
    input  logic [pva_pkg::VEL_W-1:0]           velocity,
    output logic [pva_pkg::SLOT_W-1:0]          slot,
    output logic                                slot_valid,
    output logic                                stole,
    output logic [pva_pkg::NOTE_W-1:0]          note_out,
    output logic [pva_pkg::VEL_W-1:0]           velocity_out,
    output logic [pva_pkg::MASK_W-1:0]          changed_mask,
    output logic [pva_pkg::COUNT_W-1:0]         active_count,
    output logic [pva_pkg::SLOT_W-1:0]          primary_slot,
    output logic                                primary_valid
);

    localparam int IW     = $clog2(VOICES);
    localparam int CW     = $clog2(VOICES + 1);
    localparam int WORD_W = pva_pkg::NOTE_W + pva_pkg::STAMP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);

    // request
    pva_pkg::req_t                 req_reg;
    logic [pva_pkg::NOTE_W-1:0]    note_reg;
    logic [pva_pkg::VEL_W-1:0]     vel_reg;

    // per-slot flags and stamp counter
    logic [VOICES-1:0]             valid_reg, valid_next;
    logic [VOICES-1:0]             gate_reg, gate_next;
    logic [pva_pkg::STAMP_W-1:0]   stamp_ctr_reg, stamp_ctr_next;

    // note and stamp per slot
    logic [WORD_W-1:0]             mem [VOICES];
    logic [WORD_W-1:0]             rdata_reg;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [pva_pkg::NOTE_W-1:0]    rd_note;
    logic [pva_pkg::STAMP_W-1:0]   rd_stamp;

    // scan sequencing
    logic [IW-1:0]                 cnt_reg;
    logic                          run_reg;
    logic                          rd_vld_reg;
    logic [IW-1:0]                 rd_idx_reg;
    logic                          rd_gate;
    logic                          rd_tag;

    // search accumulators
    logic [IW-1:0]                 all_idx_reg;
    logic [pva_pkg::STAMP_W-1:0]   all_stamp_reg;
    logic [pva_pkg::NOTE_W-1:0]    all_note_reg;
    logic                          ung_found_reg;
    logic [IW-1:0]                 ung_idx_reg;
    logic [pva_pkg::STAMP_W-1:0]   ung_stamp_reg;
    logic [pva_pkg::NOTE_W-1:0]    ung_note_reg;
    logic                          off_found_reg;
    logic [IW-1:0]                 off_idx_reg;

    // tally accumulators
    logic                          bg_found_reg;
    logic [IW-1:0]                 bg_idx_reg;
    logic [pva_pkg::STAMP_W-1:0]   bg_stamp_reg;
    logic                          br_found_reg;
    logic [IW-1:0]                 br_idx_reg;
    logic [pva_pkg::STAMP_W-1:0]   br_stamp_reg;
    logic [CW-1:0]                 count_reg;

    // per-request result
    logic [IW-1:0]                 res_slot_reg, res_slot_next;
    logic                          res_slot_valid_reg, res_slot_valid_next;
    logic                          res_stole_reg, res_stole_next;
    logic [pva_pkg::NOTE_W-1:0]    res_note_reg, res_note_next;
    logic [pva_pkg::VEL_W-1:0]     res_vel_reg, res_vel_next;
    logic [VOICES-1:0]             res_mask_reg, res_mask_next;

    // published result
    logic [pva_pkg::SLOT_W-1:0]    pub_slot_reg;
    logic                          pub_slot_valid_reg;
    logic                          pub_stole_reg;
    logic [pva_pkg::NOTE_W-1:0]    pub_note_reg;
    logic [pva_pkg::VEL_W-1:0]     pub_vel_reg;
    logic [pva_pkg::MASK_W-1:0]    pub_mask_reg;
    logic [pva_pkg::COUNT_W-1:0]   pub_count_reg;
    logic [pva_pkg::SLOT_W-1:0]    pub_prim_reg;
    logic                          pub_prim_valid_reg;

    // apply helpers
    logic [VOICES-1:0]             free_vec;
    logic                          free_any;
    logic [IW-1:0]                 free_idx;
    logic [IW-1:0]                 tgt_idx;
    logic [pva_pkg::NOTE_W-1:0]    tgt_old_note;
    logic                          tgt_changed;

    // width adapters toward the 3-bit, 8-bit and 4-bit result fields
    logic [IW+2:0]                 slot_ext;
    logic [IW+2:0]                 prim_ext;
    logic [IW-1:0]                 prim_idx;
    logic [VOICES+7:0]             mask_ext;
    logic [CW+3:0]                 count_ext;

    assign rd_note  = rdata_reg[WORD_W-1 -: pva_pkg::NOTE_W];
    assign rd_stamp = rdata_reg[pva_pkg::STAMP_W-1:0];
    assign rd_gate  = gate_reg[rd_idx_reg];
    assign rd_tag   = valid_reg[rd_idx_reg];

    assign status.scan_done = rd_vld_reg && (rd_idx_reg == LAST_IDX);

    // memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= {note_reg, stamp_ctr_reg};
        if (run_reg)
            rdata_reg <= mem[cnt_reg];
    end

    // lowest free slot
    always_comb
    begin
        free_vec = ~(valid_reg | gate_reg);
        free_any = |free_vec;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                free_idx = IW'(i);
        end
    end

    // slot update for the current request
    always_comb
    begin
        valid_next          = valid_reg;
        gate_next           = gate_reg;
        stamp_ctr_next      = stamp_ctr_reg;
        mem_we              = 1'b0;
        mem_waddr           = '0;
        tgt_idx             = '0;
        tgt_old_note        = '0;
        tgt_changed         = 1'b0;
        res_slot_next       = '0;
        res_slot_valid_next = 1'b0;
        res_stole_next      = 1'b0;
        res_note_next       = '0;
        res_vel_next        = '0;
        res_mask_next       = '0;
        if (cmd.apply)
        begin
            unique case (req_reg)
                pva_pkg::REQ_NOTE_ON:
                begin
                    if (free_any)
                    begin
                        tgt_idx     = free_idx;
                        tgt_changed = 1'b1;
                    end
                    else
                    begin
                        // oldest released slot first, else the oldest of all
                        tgt_idx      = ung_found_reg ? ung_idx_reg : all_idx_reg;
                        tgt_old_note = ung_found_reg ? ung_note_reg : all_note_reg;
                        tgt_changed  = !gate_reg[tgt_idx] || !valid_reg[tgt_idx] ||
                                       (tgt_old_note != note_reg);
                        res_stole_next = 1'b1;
                    end
                    gate_next[tgt_idx]     = 1'b1;
                    valid_next[tgt_idx]    = 1'b1;
                    mem_we                 = 1'b1;
                    mem_waddr              = tgt_idx;
                    stamp_ctr_next         = stamp_ctr_reg + 64'd1;
                    res_slot_next          = tgt_idx;
                    res_slot_valid_next    = 1'b1;
                    res_note_next          = note_reg;
                    res_vel_next           = vel_reg;
                    res_mask_next[tgt_idx] = tgt_changed;
                end
                pva_pkg::REQ_NOTE_OFF:
                begin
                    if (off_found_reg)
                    begin
                        gate_next[off_idx_reg]     = 1'b0;
                        res_slot_next              = off_idx_reg;
                        res_slot_valid_next        = 1'b1;
                        res_note_next              = note_reg;
                        res_mask_next[off_idx_reg] = 1'b1;
                    end
                end
                pva_pkg::REQ_ALL_OFF:
                begin
                    gate_next     = '0;
                    res_mask_next = gate_reg;
                end
                pva_pkg::REQ_TICK:
                begin
                    valid_next    = valid_reg & gate_reg;
                    res_mask_next = valid_reg & ~gate_reg;
                end
                default:
                begin
                    res_mask_next = '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            gate_reg      <= '0;
            stamp_ctr_reg <= '0;
            cnt_reg       <= '0;
            run_reg       <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            ung_found_reg <= 1'b0;
            off_found_reg <= 1'b0;
            bg_found_reg  <= 1'b0;
            br_found_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            gate_reg      <= gate_next;
            stamp_ctr_reg <= stamp_ctr_next;
            rd_vld_reg    <= run_reg;
            rd_idx_reg    <= cnt_reg;
            if (cmd.scan_start)
            begin
                cnt_reg       <= '0;
                run_reg       <= 1'b1;
                ung_found_reg <= 1'b0;
                off_found_reg <= 1'b0;
                bg_found_reg  <= 1'b0;
                br_found_reg  <= 1'b0;
                count_reg     <= '0;
            end
            else
            begin
                if (run_reg)
                begin
                    cnt_reg <= cnt_reg + IW'(1);
                    if (cnt_reg == LAST_IDX)
                        run_reg <= 1'b0;
                end
                if (rd_vld_reg)
                begin
                    if (!rd_gate && (!ung_found_reg || rd_stamp < ung_stamp_reg))
                        ung_found_reg <= 1'b1;
                    if (!off_found_reg && rd_tag && rd_gate && (rd_note == note_reg))
                        off_found_reg <= 1'b1;
                    if (rd_gate)
                    begin
                        count_reg <= count_reg + CW'(1);
                        bg_found_reg <= 1'b1;
                    end
                    else if (rd_tag)
                        br_found_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload: indices, stamps and notes of the running best candidates
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && !cmd.scan_start)
        begin
            if ((rd_idx_reg == '0) || (rd_stamp < all_stamp_reg))
            begin
                all_idx_reg   <= rd_idx_reg;
                all_stamp_reg <= rd_stamp;
                all_note_reg  <= rd_note;
            end
            if (!rd_gate && (!ung_found_reg || rd_stamp < ung_stamp_reg))
            begin
                ung_idx_reg   <= rd_idx_reg;
                ung_stamp_reg <= rd_stamp;
                ung_note_reg  <= rd_note;
            end
            if (!off_found_reg && rd_tag && rd_gate && (rd_note == note_reg))
                off_idx_reg <= rd_idx_reg;
            if (rd_gate)
            begin
                if (!bg_found_reg || rd_stamp > bg_stamp_reg)
                begin
                    bg_idx_reg   <= rd_idx_reg;
                    bg_stamp_reg <= rd_stamp;
                end
            end
            else if (rd_tag)
            begin
                if (!br_found_reg || rd_stamp > br_stamp_reg)
                begin
                    br_idx_reg   <= rd_idx_reg;
                    br_stamp_reg <= rd_stamp;
                end
            end
        end
    end

    // request capture and per-request result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= pva_pkg::req_t'(req_type);
            note_reg <= note;
            vel_reg  <= velocity;
        end
        if (cmd.apply)
        begin
            res_slot_reg       <= res_slot_next;
            res_slot_valid_reg <= res_slot_valid_next;
            res_stole_reg      <= res_stole_next;
            res_note_reg       <= res_note_next;
            res_vel_reg        <= res_vel_next;
            res_mask_reg       <= res_mask_next;
        end
    end

    assign prim_idx  = bg_found_reg ? bg_idx_reg : (br_found_reg ? br_idx_reg : '0);
    assign slot_ext  = {3'b000, res_slot_reg};
    assign prim_ext  = {3'b000, prim_idx};
    assign mask_ext  = {8'h00, res_mask_reg};
    assign count_ext = {4'b0000, count_reg};

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            pub_slot_reg       <= slot_ext[pva_pkg::SLOT_W-1:0];
            pub_slot_valid_reg <= res_slot_valid_reg;
            pub_stole_reg      <= res_stole_reg;
            pub_note_reg       <= res_note_reg;
            pub_vel_reg        <= res_vel_reg;
            pub_mask_reg       <= mask_ext[pva_pkg::MASK_W-1:0];
            pub_count_reg      <= (count_ext > (CW+4)'(pva_pkg::ACTIVE_MAX)) ?
                                  pva_pkg::ACTIVE_MAX : count_ext[pva_pkg::COUNT_W-1:0];
            pub_prim_reg       <= prim_ext[pva_pkg::SLOT_W-1:0];
            pub_prim_valid_reg <= bg_found_reg || br_found_reg;
        end
    end

    assign slot          = pub_slot_reg;
    assign slot_valid    = pub_slot_valid_reg;
    assign stole         = pub_stole_reg;
    assign note_out      = pub_note_reg;
    assign velocity_out  = pub_vel_reg;
    assign changed_mask  = pub_mask_reg;
    assign active_count  = pub_count_reg;
    assign primary_slot  = pub_prim_reg;
    assign primary_valid = pub_prim_valid_reg;

endmodule

// ----- rtl/poly_voice_allocator_unit.sv -----
// top level of the polyphonic voice allocator with oldest-note stealing
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------------
//  in       in_valid / in_ready  req_type, note, velocity
//  out      out_valid/out_ready  slot, slot_valid, stole, note_out, velocity_out,
//                                changed_mask, active_count, primary_slot, primary_valid
//
//  a transaction runs from accept through a search pass over all VOICES slots, an update,
//  a tally pass over all slots and a publish step; both passes go through the memory's
//  registered read port, and the next request is accepted only after publish.
//  reset is asynchronous, active low; slots empty, stamp counter at zero.
//  a result held on a stalled out channel does not block the next request; the block
//  waits only when a second result is ready before the first one is taken.
module poly_voice_allocator_unit
#(
    parameter int VOICES = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [pva_pkg::NOTE_W-1:0]    note,
    input  logic [pva_pkg::VEL_W-1:0]     velocity,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pva_pkg::SLOT_W-1:0]    slot,
    output logic                          slot_valid,
    output logic                          stole,
    output logic [pva_pkg::NOTE_W-1:0]    note_out,
    output logic [pva_pkg::VEL_W-1:0]     velocity_out,
    output logic [pva_pkg::MASK_W-1:0]    changed_mask,
    output logic [pva_pkg::COUNT_W-1:0]   active_count,
    output logic [pva_pkg::SLOT_W-1:0]    primary_slot,
    output logic                          primary_valid
);

    pva_pkg::cmd_t    cmd;
    pva_pkg::status_t status;

    pva_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pva_datapath
    #(
        .VOICES (VOICES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .note          (note),
        .velocity      (velocity),
        .slot          (slot),
        .slot_valid    (slot_valid),
        .stole         (stole),
        .note_out      (note_out),
        .velocity_out  (velocity_out),
        .changed_mask  (changed_mask),
        .active_count  (active_count),
        .primary_slot  (primary_slot),
        .primary_valid (primary_valid)
    );

endmodule
